[rtl/pgprs_pkg.sv]
`default_nettype none
package pgprs_pkg;

  localparam int unsigned BLOCK_MAX_DEF = 4096;

  // Block sum of squares width and its divider/root sequencing.
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q12      = 8'd1;

  localparam logic [1:0] FMT_S16    = 2'd0;
  localparam logic [1:0] FMT_S24    = 2'd1;
  localparam logic [1:0] FMT_S32    = 2'd2;
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  localparam logic [15:0] GAIN_RESET = 16'd4096;
  localparam logic [15:0] GAIN_LIMIT = 16'd40960;

  typedef struct packed {
    logic load_in;
    logic sat;
    logic sq;
    logic acc;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic block_end;
  } sts_t;

  // Left-justify the raw word to a signed 32-bit sample.
  function automatic logic [31:0] justify(input logic [1:0] fmt, input logic [31:0] raw);
    logic [31:0] res;
    begin
      case (fmt)
        FMT_S16: res = {raw[15:0], 16'h0000};
        FMT_S24: res = {raw[23:0], 8'h00};
        default: res = raw;
      endcase
      return res;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/pcm_gain_peak_rms_stats_top.sv]
// An accepted item passes through the saturate, square and accumulate states, and
// its result is loaded once the previous result has gone. An item that ends a block
// also runs the one-bit-per-cycle mean divider and two-bit-per-cycle square root.
// One item is in work at a time; a new item is taken while the previous result waits.
// Synchronous active-low reset clears the statistics, the sample total and the
// handshake state, and sets sample_format to 24-bit and the gain to unity.
`default_nettype none
module pcm_gain_peak_rms_stats_top #(
  parameter int unsigned BLOCK_MAX = pgprs_pkg::BLOCK_MAX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pgprs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pgprs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [31:0]                        in_raw_word,
  input  wire logic                               in_last_in_block,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [31:0]                      out_sample_out,
  output logic                                    out_stats_valid,
  output logic [30:0]                             out_peak_level,
  output logic [31:0]                             out_rms_scaled,
  output logic [12:0]                             out_block_count,
  output logic [31:0]                             out_total_samples
);

  pgprs_pkg::cmd_t cmd;
  pgprs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pgprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pgprs_dp #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_raw_word       (in_raw_word),
    .in_last_in_block  (in_last_in_block),
    .cmd               (cmd),
    .sts               (sts),
    .out_sample_out    (out_sample_out),
    .out_stats_valid   (out_stats_valid),
    .out_peak_level    (out_peak_level),
    .out_rms_scaled    (out_rms_scaled),
    .out_block_count   (out_block_count),
    .out_total_samples (out_total_samples)
  );

endmodule
`default_nettype wire

[rtl/pgprs_ctrl.sv]
`default_nettype none
module pgprs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pgprs_pkg::sts_t   sts,
  output pgprs_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SAT,
    S_SQ,
    S_ACC,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pgprs_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;
  logic                            div_last, sqrt_last;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign div_last  = (cnt_r == pgprs_pkg::STEP_W'(pgprs_pkg::DIV_STEPS - 1));
  assign sqrt_last = (cnt_r == pgprs_pkg::STEP_W'(pgprs_pkg::SQRT_STEPS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.block_end) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) begin
          cmd.sqrt_start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (sqrt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // The result register is reloaded only once its previous item has gone.
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/pgprs_dp.sv]
`default_nettype none
module pgprs_dp #(
  parameter int unsigned BLOCK_MAX = pgprs_pkg::BLOCK_MAX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [pgprs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pgprs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [31:0]                        in_raw_word,
  input  wire logic                               in_last_in_block,
  input  wire pgprs_pkg::cmd_t                    cmd,
  output pgprs_pkg::sts_t                         sts,
  output logic signed [31:0]                      out_sample_out,
  output logic                                    out_stats_valid,
  output logic [30:0]                             out_peak_level,
  output logic [31:0]                             out_rms_scaled,
  output logic [12:0]                             out_block_count,
  output logic [31:0]                             out_total_samples
);

  localparam int unsigned LEN_W = $clog2(BLOCK_MAX + 1);
  localparam int unsigned CNT_W = (LEN_W > 13) ? LEN_W : 13;
  localparam int unsigned SW    = pgprs_pkg::SUM_W;

  logic [1:0]        fmt_r;
  logic [15:0]       gain_r;
  logic              neg_r, last_r, end_r;
  logic [47:0]       product_r;
  logic [31:0]       s_r;
  logic [31:0]       sq_r;
  logic [SW-1:0]     sum_r;
  logic [30:0]       peak_r;
  logic [LEN_W-1:0]  len_r;
  logic [31:0]       total_r;
  logic [SW-1:0]     quo_r;
  logic [LEN_W-1:0]  rem_r;
  logic [31:0]       sv_r;
  logic [16:0]       srem_r;
  logic [15:0]       root_r;

  logic [31:0]       just;
  logic [31:0]       in_mag;
  logic [35:0]       q;
  logic [31:0]       s_nxt;
  logic signed [15:0] top;
  logic [30:0]       s_mag;
  logic [LEN_W-1:0]  len_inc;
  logic [SW-1:0]     sum_nxt;
  logic [LEN_W:0]    dtrial, ddiff;
  logic              dge;
  logic [LEN_W-1:0]  rem_nxt;
  logic [SW-1:0]     quo_nxt;
  logic [18:0]       strial, ssub, sdiff;
  logic              sge;
  logic [CNT_W-1:0]  len_ext;

  assign sts.block_end = end_r;

  assign just   = pgprs_pkg::justify(fmt_r, in_raw_word);
  assign in_mag = just[31] ? (~just + 32'd1) : just;

  // Truncated product magnitude, clamped to the signed range.
  assign q = product_r[47:12];
  always_comb begin
    if (neg_r) begin
      s_nxt = (q >= 36'h080000000) ? 32'h80000000 : (~q[31:0] + 32'd1);
    end else begin
      s_nxt = (q > 36'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    end
  end

  assign top   = s_r[31:16];
  assign s_mag = (s_r == 32'h80000000) ? 31'h7FFFFFFF :
                 (s_r[31] ? (~s_r[30:0] + 31'd1) : s_r[30:0]);
  assign len_inc = len_r + 1'b1;
  assign sum_nxt = sum_r + SW'(sq_r);

  // Restoring divider, one quotient bit a cycle; quo_r shifts the dividend out.
  assign dtrial  = {rem_r, quo_r[SW-1]};
  assign dge     = (dtrial >= {1'b0, len_r});
  assign ddiff   = dtrial - {1'b0, len_r};
  assign rem_nxt = dge ? ddiff[LEN_W-1:0] : dtrial[LEN_W-1:0];
  assign quo_nxt = {quo_r[SW-2:0], dge};

  // Integer square root, two radicand bits a cycle.
  assign strial = {srem_r, sv_r[31:30]};
  assign ssub   = {1'b0, root_r, 2'b01};
  assign sge    = (strial >= ssub);
  assign sdiff  = strial - ssub;

  assign len_ext = CNT_W'(len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= pgprs_pkg::FMT_S24;
      gain_r  <= pgprs_pkg::GAIN_RESET;
      sum_r   <= '0;
      peak_r  <= '0;
      len_r   <= '0;
      total_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pgprs_pkg::REG_SAMPLE_FORMAT: begin
            if (cfg_wdata[1:0] != pgprs_pkg::FMT_UNUSED) begin
              fmt_r <= cfg_wdata[1:0];
            end
          end
          pgprs_pkg::REG_GAIN_Q12: begin
            if (cfg_wdata <= pgprs_pkg::GAIN_LIMIT) begin
              gain_r <= cfg_wdata;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.sq) begin
        if (s_mag > peak_r) begin
          peak_r <= s_mag;
        end
        len_r   <= len_inc;
        total_r <= total_r + 32'd1;
      end
      if (cmd.acc) begin
        sum_r <= sum_nxt;
      end
      if (cmd.out_load && end_r) begin
        sum_r  <= '0;
        peak_r <= '0;
        len_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      neg_r     <= just[31];
      last_r    <= in_last_in_block;
      product_r <= in_mag * gain_r;
    end
    if (cmd.sat) begin
      s_r <= s_nxt;
    end
    if (cmd.sq) begin
      sq_r  <= 32'($signed(top) * $signed(top));
      end_r <= last_r || (len_inc >= LEN_W'(BLOCK_MAX));
    end
    if (cmd.div_start) begin
      quo_r <= sum_nxt;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.sqrt_start) begin
      sv_r   <= quo_nxt[31:0];
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sv_r   <= {sv_r[29:0], 2'b00};
      srem_r <= sge ? sdiff[16:0] : strial[16:0];
      root_r <= {root_r[14:0], sge};
    end
    if (cmd.out_load) begin
      out_sample_out    <= s_r;
      out_total_samples <= total_r;
      out_stats_valid   <= end_r;
      out_peak_level    <= end_r ? peak_r : 31'd0;
      out_rms_scaled    <= end_r ? {root_r, 16'h0000} : 32'd0;
      out_block_count   <= end_r ? len_ext[12:0] : 13'd0;
    end
  end

endmodule
`default_nettype wire

[rtl/pgprs_chk.sv]
`default_nettype none
module pgprs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_sample_out,
  input wire logic        out_stats_valid,
  input wire logic [30:0] out_peak_level,
  input wire logic [31:0] out_rms_scaled,
  input wire logic [12:0] out_block_count
);

  // A stalled item keeps its sample.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result item changed while stalled");

  // Items that do not end a block carry no statistics.
  a_no_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stats_valid |->
      out_peak_level == 31'd0 && out_rms_scaled == 32'd0 && out_block_count == 13'd0)
    else $error("statistics present on an item that does not end a block");

  // A finished block always holds at least one sample.
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stats_valid |-> out_block_count != 13'd0)
    else $error("block ended with no samples");

  // The root is scaled by 65536, so its low half is always clear.
  a_rms_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_scaled[15:0] == 16'h0000)
    else $error("rms level not a multiple of 65536");

endmodule

bind pcm_gain_peak_rms_stats_top pgprs_chk u_pgprs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sample_out  (out_sample_out),
  .out_stats_valid (out_stats_valid),
  .out_peak_level  (out_peak_level),
  .out_rms_scaled  (out_rms_scaled),
  .out_block_count (out_block_count)
);
`default_nettype wire
